>>> hdl/mmcs_pkg.sv
// ----------------------------------------------------------------------------
// mmcs_pkg
// Shared types and constants for the min/max contrast stretch block.
// ----------------------------------------------------------------------------
package mmcs_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned PROD_W      = 2 * PIX_W;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;
  localparam logic [PIX_W-1:0] ZERO_LEVEL = 8'd0;

  // Input operation codes
  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_MAP     = 1'b1;

  typedef enum logic {
    KIND_PASS,  // result already known, no division
    KIND_DIV    // result is num / span
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [PIX_W-1:0]   value;
    logic [PROD_W-1:0]  num;
    logic [PIX_W-1:0]   span;
  } job_t;

endpackage

>>> hdl/mmcs_front.sv
// ----------------------------------------------------------------------------
// mmcs_front
// Accepts pixels, tracks the running min/max and classifies map pixels
// into finished results or division jobs.
// ----------------------------------------------------------------------------
module mmcs_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          op_i,
  input  logic [mmcs_pkg::PIX_W-1:0]    pixel_i,
  input  logic                          first_i,
  output logic                          job_push_o,
  output mmcs_pkg::job_t                job_o
);

  logic [mmcs_pkg::PIX_W-1:0]  lo_q, lo_d;
  logic [mmcs_pkg::PIX_W-1:0]  hi_q, hi_d;
  logic [mmcs_pkg::PIX_W-1:0]  diff;
  logic [mmcs_pkg::PIX_W-1:0]  span;
  logic [mmcs_pkg::PROD_W-1:0] prod;

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (accept_i && (op_i == mmcs_pkg::OP_MEASURE)) begin
      if (first_i) begin
        lo_d = pixel_i;
        hi_d = pixel_i;
      end else begin
        if (pixel_i > hi_q) hi_d = pixel_i;
        if (pixel_i < lo_q) lo_d = pixel_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= '0;
      hi_q <= '0;
    end else begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  // (p - lo) * 255 as (d << 8) - d
  always_comb begin
    diff = pixel_i - lo_q;
    span = hi_q - lo_q;
    prod = {diff, {mmcs_pkg::PIX_W{1'b0}}} - {{mmcs_pkg::PIX_W{1'b0}}, diff};
  end

  always_comb begin
    job_o.kind  = mmcs_pkg::KIND_PASS;
    job_o.value = mmcs_pkg::ZERO_LEVEL;
    job_o.num   = prod;
    job_o.span  = span;
    if (pixel_i < lo_q) begin
      job_o.value = mmcs_pkg::ZERO_LEVEL;
    end else if (pixel_i > hi_q) begin
      job_o.value = mmcs_pkg::FULL_SCALE;
    end else if (span == '0) begin
      job_o.value = mmcs_pkg::ZERO_LEVEL;
    end else begin
      job_o.kind = mmcs_pkg::KIND_DIV;
    end
  end

  assign job_push_o = accept_i && (op_i == mmcs_pkg::OP_MAP);

endmodule

>>> hdl/mmcs_queue.sv
// ----------------------------------------------------------------------------
// mmcs_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module mmcs_queue #(
  parameter int unsigned Depth = mmcs_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mmcs_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output mmcs_pkg::job_t job_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  mmcs_pkg::job_t  slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= job_i;
  end

endmodule

>>> hdl/mmcs_back.sv
// ----------------------------------------------------------------------------
// mmcs_back
// Takes jobs from the queue, runs a bit-serial restoring divider for
// in-range pixels and holds the result until it is popped.
// ----------------------------------------------------------------------------
module mmcs_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_empty_i,
  input  mmcs_pkg::job_t             job_i,
  output logic                       job_pop_o,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic [mmcs_pkg::PIX_W-1:0] stretched_o
);

  localparam int unsigned W    = mmcs_pkg::PIX_W;
  localparam int unsigned CntW = $clog2(W);

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    rem_q;
  logic [W-1:0]    dvd_q;
  logic [W-1:0]    quo_q;
  logic [W-1:0]    span_q;
  logic            res_valid_q;
  logic [W-1:0]    res_q;

  logic            res_free;
  logic            div_last;
  logic            res_set;
  logic [W:0]      trial;
  logic            ge;
  logic [W-1:0]    rem_next;
  logic [W-1:0]    quo_next;

  assign res_free  = !res_valid_q || pop_i;
  assign job_pop_o = (state_q == ST_IDLE) && !job_empty_i && res_free;
  assign div_last  = (cnt_q == CntW'(W - 1));
  assign res_set   = (job_pop_o && (job_i.kind == mmcs_pkg::KIND_PASS)) ||
                     ((state_q == ST_DIV) && div_last && res_free);

  always_comb begin
    trial    = {rem_q, dvd_q[W-1]};
    ge       = (trial >= {1'b0, span_q});
    rem_next = ge ? W'(trial - {1'b0, span_q}) : trial[W-1:0];
    quo_next = {quo_q[W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rem_q       <= '0;
      dvd_q       <= '0;
      quo_q       <= '0;
      span_q      <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (res_set) begin
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (job_pop_o) begin
            // High byte of the dividend is below span, so it seeds the remainder
            rem_q  <= job_i.num[mmcs_pkg::PROD_W-1:W];
            dvd_q  <= job_i.num[W-1:0];
            span_q <= job_i.span;
            quo_q  <= '0;
            if (job_i.kind == mmcs_pkg::KIND_PASS) begin
              res_q <= job_i.value;
            end else begin
              state_q <= ST_DIV;
              cnt_q   <= '0;
            end
          end
        end
        ST_DIV: begin
          // Hold on the last step until the result register frees up
          if (!div_last) begin
            cnt_q <= cnt_q + 1'b1;
            rem_q <= rem_next;
            dvd_q <= {dvd_q[W-2:0], 1'b0};
            quo_q <= quo_next;
          end else if (res_free) begin
            res_q   <= quo_next;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign empty_o     = !res_valid_q;
  assign stretched_o = res_q;

endmodule

>>> hdl/min_max_contrast_stretch.sv
// Map pixels outside the range or on a flat range pass the job queue into the
// result register; the others also pass the bit-serial divider, one at a time.
// Throughput: one measure pixel per cycle while the queue is not full; the
// divider gives one quotient bit a cycle, stalling its last until res_q frees.
// Reset: rst_ni clears min/max to 0, empties the job queue and the result.
// ----------------------------------------------------------------------------
// min_max_contrast_stretch
// Linear min/max contrast stretch of an 8-bit grey pixel stream.
// ----------------------------------------------------------------------------
module min_max_contrast_stretch #(
  parameter int unsigned QueueDepth = mmcs_pkg::QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic                       op_i,
  input  logic [mmcs_pkg::PIX_W-1:0] pixel_i,
  input  logic                       first_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [mmcs_pkg::PIX_W-1:0] stretched_o
);

  logic           accept;
  logic           job_push;
  mmcs_pkg::job_t job_in;
  mmcs_pkg::job_t job_head;
  logic           job_full;
  logic           job_empty;
  logic           job_pop;

  assign full   = job_full;
  assign accept = push && !full;

  mmcs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .op_i       (op_i),
    .pixel_i    (pixel_i),
    .first_i    (first_i),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  mmcs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .job_o   (job_head),
    .empty_o (job_empty)
  );

  mmcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .stretched_o (stretched_o)
  );

  a_map_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (op_i == mmcs_pkg::OP_MAP) |=> !job_empty)
    else $error("accepted map pixel did not reach the job queue");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> !job_empty)
    else $error("back took a job from an empty queue");

  a_div_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop && (job_head.kind == mmcs_pkg::KIND_DIV) |->
      (job_head.span != '0) &&
      (job_head.num[mmcs_pkg::PROD_W-1:mmcs_pkg::PIX_W] < job_head.span))
    else $error("division job with zero span or oversized quotient");

endmodule
